// File: sv/qti_pkg.sv
// qti_pkg: shared widths, table geometry and types for the table interpolator
// depends on nothing; used by every module of the block
package qti_pkg;

    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // axis index widths (dimensions 8, 32, 8, 32)
    localparam int IA_W = 3;
    localparam int IB_W = 5;
    localparam int IC_W = 3;
    localparam int ID_W = 5;

    // banked by the low bit of each index: 16 banks
    localparam int NUM_BANKS = 16;
    localparam int BANK_W    = 4;
    localparam int BADDR_W   = (IA_W - 1) + (IB_W - 1) + (IC_W - 1) + (ID_W - 1);
    localparam int BANK_DEPTH = 1 << BADDR_W;

    localparam int DIFF_W = VALUE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [FRAC_W-1:0]            t_frac;
    typedef logic [BADDR_W-1:0]           t_baddr;
    typedef logic signed [PROD_W-1:0]     t_prod;

    // control that travels beside the data
    typedef struct packed {
        logic        valid;
        logic        bad;
        logic        a_zero;
        logic [BANK_W-1:0] lsb;
        t_frac       f0;
        t_frac       f1;
        t_frac       f2;
        t_frac       f3;
    } t_ctrl;

    function automatic t_frac clamp_frac(input logic [FRAC_W-1:0] f);
        clamp_frac = (f > FRAC_ONE) ? FRAC_ONE : f;
    endfunction

    // finish a blend: a + floor(p / 2^FRAC_BITS)
    function automatic t_value lerp_sum(input t_value a, input t_prod p);
        logic signed [DIFF_W-1:0] s;
        s = DIFF_W'(a) + p[FRAC_BITS+DIFF_W-1:FRAC_BITS];
        lerp_sum = s[VALUE_BITS-1:0];
    endfunction

endpackage

// File: sv/qti_bank.sv
// qti_bank: one bank of the table store, one write port and one read port, registered read
// depends on qti_pkg
module qti_bank (
    input  logic               i_clk,
    input  logic               i_we,
    input  qti_pkg::t_baddr    i_waddr,
    input  qti_pkg::t_value    i_wdata,
    input  qti_pkg::t_baddr    i_raddr,
    output qti_pkg::t_value    o_rdata
);

    qti_pkg::t_value r_mem [qti_pkg::BANK_DEPTH];
    qti_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/qti_lerp.sv
// qti_lerp: first half of one blend, registers a and (b-a)*f
// depends on qti_pkg; the sum is finished by qti_pkg::lerp_sum on the registered outputs
module qti_lerp (
    input  logic               i_clk,
    input  qti_pkg::t_value    i_a,
    input  qti_pkg::t_value    i_b,
    input  qti_pkg::t_frac     i_f,
    output qti_pkg::t_value    o_a,
    output qti_pkg::t_prod     o_p
);

    logic signed [qti_pkg::DIFF_W-1:0] diff;
    logic signed [qti_pkg::FRAC_W:0]   fs;
    qti_pkg::t_value r_a;
    qti_pkg::t_prod  r_p;

    assign diff = qti_pkg::DIFF_W'(i_b) - qti_pkg::DIFF_W'(i_a);
    assign fs   = {1'b0, i_f};

    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_p <= qti_pkg::PROD_W'(diff) * qti_pkg::PROD_W'(fs);
    end

    assign o_a = r_a;
    assign o_p = r_p;

endmodule

// File: sv/quadrilinear_table_interpolator.sv
// throughput: one request per cycle, writes and queries alike; busy stays low
// the table sits in 16 banks chosen by the low bit of each index, so all corners read at once
// reset (i_rst_n low, synchronous) clears the valid pipeline; table contents stay undefined
// the receiver cannot stall, so the pipeline never holds
module quadrilinear_table_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [2:0]  i_idx_pv_variance,
    input  logic [4:0]  i_idx_pv,
    input  logic [2:0]  i_idx_z_variance,
    input  logic [4:0]  i_idx_z,
    input  logic [16:0] i_frac_pv_variance,
    input  logic [16:0] i_frac_pv,
    input  logic [16:0] i_frac_z_variance,
    input  logic [16:0] i_frac_z,
    input  logic signed [31:0] i_write_value,
    output logic        o_valid,
    output logic signed [31:0] o_interp_value,
    output logic        o_range_error
);

    localparam int NB = qti_pkg::NUM_BANKS;

    logic accept;
    logic is_write;
    logic is_query;
    logic [qti_pkg::BANK_W-1:0] wbank;
    qti_pkg::t_baddr waddr;
    logic [qti_pkg::IA_W-1:0] ia_eff;
    logic [qti_pkg::BANK_W-1:0] lsb;

    qti_pkg::t_baddr raddr [NB];
    qti_pkg::t_value rdata [NB];

    qti_pkg::t_ctrl n_c1, r_c1, r_c2, r_c3, r_c4, r_c5;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_write = accept && !i_action;
    assign is_query = accept && i_action;

    // write lands in the bank given by the index low bits
    assign wbank = {i_idx_pv_variance[0], i_idx_pv[0], i_idx_z_variance[0], i_idx_z[0]};
    assign waddr = {i_idx_pv_variance[qti_pkg::IA_W-1:1], i_idx_pv[qti_pkg::IB_W-1:1],
                    i_idx_z_variance[qti_pkg::IC_W-1:1], i_idx_z[qti_pkg::ID_W-1:1]};

    // with no first-axis blend read slices 0 and 1, then keep slice 0
    assign ia_eff = (i_idx_pv_variance == '0) ? qti_pkg::IA_W'(1) : i_idx_pv_variance;
    assign lsb    = {ia_eff[0], i_idx_pv[0], i_idx_z_variance[0], i_idx_z[0]};

    for (genvar g = 0; g < NB; g++) begin : g_bank
        localparam logic [3:0] GB = 4'(g);
        logic [qti_pkg::IA_W-1:0] xa;
        logic [qti_pkg::IB_W-1:0] xb;
        logic [qti_pkg::IC_W-1:0] xc;
        logic [qti_pkg::ID_W-1:0] xd;
        // bank holds the upper index when parity matches, else the lower one
        assign xa = (ia_eff[0] == GB[3]) ? ia_eff : ia_eff - 1'b1;
        assign xb = (i_idx_pv[0] == GB[2]) ? i_idx_pv : i_idx_pv - 1'b1;
        assign xc = (i_idx_z_variance[0] == GB[1]) ? i_idx_z_variance : i_idx_z_variance - 1'b1;
        assign xd = (i_idx_z[0] == GB[0]) ? i_idx_z : i_idx_z - 1'b1;
        assign raddr[g] = {xa[qti_pkg::IA_W-1:1], xb[qti_pkg::IB_W-1:1],
                           xc[qti_pkg::IC_W-1:1], xd[qti_pkg::ID_W-1:1]};

        qti_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (is_write && (wbank == GB)),
            .i_waddr (waddr),
            .i_wdata (i_write_value),
            .i_raddr (raddr[g]),
            .o_rdata (rdata[g])
        );
    end

    // request decode; zero index on a blended axis is an error
    always_comb begin
        n_c1.valid  = is_query;
        n_c1.bad    = (i_idx_pv == '0) || (i_idx_z_variance == '0) || (i_idx_z == '0);
        n_c1.a_zero = (i_idx_pv_variance == '0);
        n_c1.lsb    = lsb;
        n_c1.f0     = qti_pkg::clamp_frac(i_frac_pv_variance);
        n_c1.f1     = qti_pkg::clamp_frac(i_frac_pv);
        n_c1.f2     = qti_pkg::clamp_frac(i_frac_z_variance);
        n_c1.f3     = qti_pkg::clamp_frac(i_frac_z);
    end

    // stage 1: sort bank outputs into corners, first-axis blend products
    qti_pkg::t_value lo1 [8];
    qti_pkg::t_value hi1 [8];
    qti_pkg::t_value a2  [8];
    qti_pkg::t_prod  p2  [8];

    for (genvar k = 0; k < 8; k++) begin : g_ax0
        // corner k: bit0 pv upper, bit1 z_variance upper, bit2 z upper
        localparam logic [2:0] KB = 3'(k);
        localparam logic [3:0] UL = {1'b0, KB[0], KB[1], KB[2]};
        localparam logic [3:0] UH = {1'b1, KB[0], KB[1], KB[2]};
        assign lo1[k] = rdata[UL ^ ~r_c1.lsb];
        assign hi1[k] = r_c1.a_zero ? lo1[k] : rdata[UH ^ ~r_c1.lsb];
        qti_lerp u_l (.i_clk(i_clk), .i_a(lo1[k]), .i_b(hi1[k]), .i_f(r_c1.f0),
                      .o_a(a2[k]), .o_p(p2[k]));
    end

    // stage 2: pv axis
    qti_pkg::t_value c2 [8];
    qti_pkg::t_value a3 [4];
    qti_pkg::t_prod  p3 [4];
    for (genvar k = 0; k < 8; k++) begin : g_c2
        assign c2[k] = qti_pkg::lerp_sum(a2[k], p2[k]);
    end
    for (genvar k = 0; k < 4; k++) begin : g_ax1
        qti_lerp u_l (.i_clk(i_clk), .i_a(c2[2*k]), .i_b(c2[2*k+1]), .i_f(r_c2.f1),
                      .o_a(a3[k]), .o_p(p3[k]));
    end

    // stage 3: z_variance axis
    qti_pkg::t_value m3 [4];
    qti_pkg::t_value a4 [2];
    qti_pkg::t_prod  p4 [2];
    for (genvar k = 0; k < 4; k++) begin : g_m3
        assign m3[k] = qti_pkg::lerp_sum(a3[k], p3[k]);
    end
    for (genvar k = 0; k < 2; k++) begin : g_ax2
        qti_lerp u_l (.i_clk(i_clk), .i_a(m3[2*k]), .i_b(m3[2*k+1]), .i_f(r_c3.f2),
                      .o_a(a4[k]), .o_p(p4[k]));
    end

    // stage 4: z axis
    qti_pkg::t_value n4 [2];
    qti_pkg::t_value a5;
    qti_pkg::t_prod  p5;
    assign n4[0] = qti_pkg::lerp_sum(a4[0], p4[0]);
    assign n4[1] = qti_pkg::lerp_sum(a4[1], p4[1]);
    qti_lerp u_l3 (.i_clk(i_clk), .i_a(n4[0]), .i_b(n4[1]), .i_f(r_c4.f3),
                   .o_a(a5), .o_p(p5));

    // stage 5: finish and drive the result register
    qti_pkg::t_value res5;
    logic            r_valid;
    logic            r_err;
    qti_pkg::t_value r_value;
    assign res5 = qti_pkg::lerp_sum(a5, p5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1.valid <= 1'b0;
            r_c2.valid <= 1'b0;
            r_c3.valid <= 1'b0;
            r_c4.valid <= 1'b0;
            r_c5.valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            r_c5 <= r_c4;
            r_valid <= r_c5.valid;
        end
        r_err   <= r_c5.bad;
        r_value <= r_c5.bad ? '0 : res5;
    end

    assign o_valid        = r_valid;
    assign o_interp_value = r_value;
    assign o_range_error  = r_err;

endmodule

// File: sv/qti_checker.sv
// qti_checker: port-level checks on the table interpolator, bound to the top level
// depends on quadrilinear_table_interpolator
module qti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_action,
    input logic [4:0]  i_idx_pv,
    input logic        o_valid,
    input logic signed [31:0] o_interp_value,
    input logic        o_range_error
);

    a_valid_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && i_action, 6))
        else $error("result without a query request");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_interp_value == 0))
        else $error("error result carries a value");

    a_zero_idx_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_idx_pv == 5'd0, 6)) |-> o_range_error)
        else $error("zero pv index not flagged");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind quadrilinear_table_interpolator qti_checker u_qti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_action       (i_action),
    .i_idx_pv       (i_idx_pv),
    .o_valid        (o_valid),
    .o_interp_value (o_interp_value),
    .o_range_error  (o_range_error)
);

// File: tb/sv/tb_quadrilinear_table_interpolator.sv
// testbench for quadrilinear_table_interpolator: writes table entries, then queries
// 4d blends and checks every result against a scoreboard that predicts it
// depends on qti_pkg and the block's rtl
module tb_quadrilinear_table_interpolator;

    localparam int N_ITEMS = 2000;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        qti_pkg::t_value value;
        logic   err;
    } t_interp_result;

    // predicts interpolated values from its own copy of the table
    class interp_scoreboard;
        longint table_mem[int];
        t_interp_result pending[$];

        function int entry_addr(int unsigned a, int unsigned b, int unsigned c, int unsigned d);
            return ((a * 32 + b) * 8 + c) * 32 + d;
        endfunction

        // a*(1-f)+b*f with floor, f in Q1.16
        function longint mix(longint a, longint b, longint f);
            if (f >= 65536) return b;
            return a + (((b - a) * f) >>> qti_pkg::FRAC_BITS);
        endfunction

        function longint clamp(logic [16:0] f);
            return (f > qti_pkg::FRAC_ONE) ? 65536 : longint'(f);
        endfunction

        function void note_request(logic act, logic [2:0] ia, logic [4:0] ib,
                logic [2:0] ic, logic [4:0] id, logic [16:0] fa, logic [16:0] fb,
                logic [16:0] fc, logic [16:0] fd, logic signed [31:0] wv);
            t_interp_result r;
            longint crn[8];
            longint m[4];
            longint n0, n1, res, f0, f1, f2, f3;
            int unsigned lo, b, c, d;
            if (!act) begin
                table_mem[entry_addr(ia, ib, ic, id)] = longint'(wv);
                return;
            end
            if (ib == 0 || ic == 0 || id == 0) begin
                r.value = '0;
                r.err = 1'b1;
                pending.push_back(r);
                return;
            end
            f0 = clamp(fa);
            f1 = clamp(fb);
            f2 = clamp(fc);
            f3 = clamp(fd);
            lo = (ia == 0) ? 0 : ia - 1;
            for (int k = 0; k < 8; k++) begin
                b = k[0] ? ib : ib - 1;
                c = k[1] ? ic : ic - 1;
                d = k[2] ? id : id - 1;
                if (ia == 0)
                    crn[k] = table_mem[entry_addr(0, b, c, d)];
                else
                    crn[k] = mix(table_mem[entry_addr(lo, b, c, d)],
                                 table_mem[entry_addr(ia, b, c, d)], f0);
            end
            for (int k = 0; k < 4; k++)
                m[k] = mix(crn[2*k], crn[2*k+1], f1);
            n0 = mix(m[0], m[1], f2);
            n1 = mix(m[2], m[3], f2);
            res = mix(n0, n1, f3);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            r.value = qti_pkg::t_value'(res);
            r.err = 1'b0;
            pending.push_back(r);
        endfunction

        // returns an empty string when the result matches the oldest expectation
        function string check_result(qti_pkg::t_value v, logic e);
            t_interp_result x;
            if (pending.size() == 0)
                return $sformatf("unexpected result value=%0d err=%0b", v, e);
            x = pending.pop_front();
            if (v !== x.value || e !== x.err)
                return $sformatf("result value=%0d err=%0b, predicted value=%0d err=%0b",
                                 v, e, x.value, x.err);
            return "";
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [2:0]  i_idx_pv_variance = '0;
    logic [4:0]  i_idx_pv = '0;
    logic [2:0]  i_idx_z_variance = '0;
    logic [4:0]  i_idx_z = '0;
    logic [16:0] i_frac_pv_variance = '0;
    logic [16:0] i_frac_pv = '0;
    logic [16:0] i_frac_z_variance = '0;
    logic [16:0] i_frac_z = '0;
    logic signed [31:0] i_write_value = '0;
    logic        o_valid;
    logic signed [31:0] o_interp_value;
    logic        o_range_error;

    interp_scoreboard sb = new();
    int n_errors = 0;
    int n_sent = 0;
    int idle_cycles = 0;
    bit burst_mode = 1'b0;

    quadrilinear_table_interpolator dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    // result side: the receiver cannot stall, so every strobe is checked
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid) begin
            msg = sb.check_result(o_interp_value, o_range_error);
            if (msg != "") report(msg);
        end
    end

    // watchdog: cycles with neither a request nor a result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_quadrilinear_table_interpolator NOT OK");
                $finish;
            end
        end
    end

    // drive one request and hold it until accepted, then maybe idle
    task automatic send(logic act, logic [2:0] ia, logic [4:0] ib, logic [2:0] ic,
            logic [4:0] id, logic [16:0] fa, logic [16:0] fb, logic [16:0] fc,
            logic [16:0] fd, logic signed [31:0] wv);
        int gap;
        start <= 1'b1;
        i_action <= act;
        i_idx_pv_variance <= ia;
        i_idx_pv <= ib;
        i_idx_z_variance <= ic;
        i_idx_z <= id;
        i_frac_pv_variance <= fa;
        i_frac_pv <= fb;
        i_frac_z_variance <= fc;
        i_frac_z <= fd;
        i_write_value <= wv;
        do @(posedge i_clk); while (busy);
        sb.note_request(act, ia, ib, ic, id, fa, fb, fc, fd, wv);
        n_sent++;
        // alternate between stretches with no idling and random gaps
        if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] pick_frac();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return qti_pkg::FRAC_ONE;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic write_entry(int unsigned a, int unsigned b, int unsigned c,
            int unsigned d, logic signed [31:0] v);
        send(1'b0, 3'(a), 5'(b), 3'(c), 5'(d), pick_frac(), pick_frac(), pick_frac(),
             pick_frac(), v);
    endtask

    // a query preceded by writes of every corner it reads that is still unwritten
    task automatic query(int unsigned a, int unsigned b, int unsigned c, int unsigned d,
            logic [16:0] fa, logic [16:0] fb, logic [16:0] fc, logic [16:0] fd);
        int unsigned sa, cb, cc, cd;
        if (b != 0 && c != 0 && d != 0) begin
            for (int k = 0; k < 16; k++) begin
                sa = (a == 0) ? 0 : (k[3] ? a : a - 1);
                cb = k[0] ? b : b - 1;
                cc = k[1] ? c : c - 1;
                cd = k[2] ? d : d - 1;
                if (!sb.table_mem.exists(sb.entry_addr(sa, cb, cc, cd)))
                    write_entry(sa, cb, cc, cd, pick_value());
            end
        end
        send(1'b1, 3'(a), 5'(b), 3'(c), 5'(d), fa, fb, fc, fd, $urandom);
    endtask

    initial begin
        int unsigned a, b, c, d;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme values, edge fractions, slice-0 queries, zero indices
        write_entry(7, 31, 7, 31, 32'sh7fffffff);
        write_entry(6, 31, 7, 31, 32'sh80000000);
        query(7, 31, 7, 31, 17'h10000, 17'h10000, 17'h10000, 17'h10000);
        query(7, 31, 7, 31, 17'h08000, 17'h1ffff, 17'h0ffff, 17'h00001);
        query(7, 31, 7, 31, 17'h0, 17'h0, 17'h0, 17'h0);
        query(1, 1, 1, 1, 17'h1ffff, 17'h08000, 17'h04000, 17'h0c000);
        query(0, 1, 1, 1, 17'h1ffff, 17'h0ffff, 17'h1ffff, 17'h00000);
        query(0, 31, 7, 31, 17'h00000, 17'h08000, 17'h08000, 17'h08000);
        query(3, 0, 2, 2, 17'h08000, 17'h08000, 17'h08000, 17'h08000);
        query(3, 2, 0, 2, 17'h08000, 17'h08000, 17'h08000, 17'h08000);
        query(3, 2, 2, 0, 17'h08000, 17'h08000, 17'h08000, 17'h08000);
        query(0, 0, 0, 0, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff);

        // random: mostly well-formed write-then-query sequences in a small window
        while (n_sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0: write_entry($urandom_range(0, 7), $urandom_range(0, 31),
                               $urandom_range(0, 7), $urandom_range(0, 31), pick_value());
                1: query($urandom_range(0, 7), $urandom_range(0, 31) * $urandom_range(0, 1),
                         $urandom_range(0, 7) * $urandom_range(0, 1),
                         $urandom_range(0, 31) * $urandom_range(0, 1),
                         pick_frac(), pick_frac(), pick_frac(), pick_frac());
                2: query($urandom_range(0, 7), $urandom_range(1, 31), $urandom_range(1, 7),
                         $urandom_range(1, 31), pick_frac(), pick_frac(), pick_frac(),
                         pick_frac());
                default: begin
                    a = $urandom_range(0, 3);
                    b = $urandom_range(1, 4);
                    c = $urandom_range(1, 3);
                    d = $urandom_range(1, 4);
                    query(a, b, c, d, pick_frac(), pick_frac(), pick_frac(), pick_frac());
                end
            endcase
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("tb_quadrilinear_table_interpolator OK");
        else
            $display("tb_quadrilinear_table_interpolator NOT OK");
        $finish;
    end
endmodule

// File: sim.f
sv/qti_pkg.sv
sv/qti_bank.sv
sv/qti_lerp.sv
sv/quadrilinear_table_interpolator.sv
sv/qti_checker.sv
tb/sv/tb_quadrilinear_table_interpolator.sv
